@@ rtl/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// Positional list engine package
// Sizes, action and status codes, and the control signals that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int DEPTH    = 64;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int ACTION_W = 3;
	localparam int POS_W    = 10;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 11;

	localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_INS_POS   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_REM_FRONT = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_REM_BACK  = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_REM_POS   = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic load;
		logic check;
		logic take_rd;
		logic take_wr;
		logic move_rd;
		logic move_wr;
		logic put;
		logic publish;
	} ple_cmd_t;

	typedef struct packed {
		logic ins_ok;
		logic rem_ok;
		logic move_done;
	} ple_stat_t;

endpackage

@@ rtl/ple_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Carries one list action with its position and value.
// ----------------------------------------------------------------------------
interface ple_req_if
	import ple_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [POS_W-1:0]    position;
	logic signed [VAL_W-1:0] value_in;

	modport source (output valid, action, position, value_in, input ready);
	modport sink   (input valid, action, position, value_in, output ready);
endinterface

@@ rtl/ple_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Carries the status, the removed value and the list length after an action.
// ----------------------------------------------------------------------------
interface ple_rsp_if
	import ple_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic signed [VAL_W-1:0] value_out;
	logic [LEN_W-1:0]    length;

	modport source (output valid, status, value_out, length, input ready);
	modport sink   (input valid, status, value_out, length, output ready);
endinterface

@@ rtl/ple_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/ple_datapath.sv @@
// ----------------------------------------------------------------------------
// Positional list datapath
// Holds the current item, the entry count and the entry store, checks each
// action and moves entries one place at a time under controller command.
// ----------------------------------------------------------------------------
module ple_datapath
	import ple_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [ACTION_W-1:0]     req_action,
	input  logic [POS_W-1:0]        req_position,
	input  logic signed [VAL_W-1:0] req_value_in,
	input  ple_cmd_t                cmd,
	output ple_stat_t               stat,
	output logic [STATUS_W-1:0]     rsp_status,
	output logic signed [VAL_W-1:0] rsp_value_out,
	output logic [LEN_W-1:0]        rsp_length
);

	logic [ACTION_W-1:0] action_q;
	logic [POS_W-1:0]    pos_q;
	logic [VAL_W-1:0]    val_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    at_q;
	logic [CNT_W-1:0]    idx_q;
	logic                dir_q;
	logic [STATUS_W-1:0] status_q;
	logic [VAL_W-1:0]    taken_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [VAL_W-1:0]    out_value_q;
	logic [LEN_W-1:0]    out_length_q;

	logic [LEN_W-1:0]    count_ext;
	logic [LEN_W-1:0]    at_c;
	logic                is_ins;
	logic                is_rem;
	logic [STATUS_W-1:0] status_c;

	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [VAL_W-1:0]    ram_wdata;
	logic                ram_re;
	logic [IDX_W-1:0]    ram_raddr;
	logic [VAL_W-1:0]    ram_rdata;
	logic [CNT_W-1:0]    idx_dn;
	logic [CNT_W-1:0]    idx_up;

	assign count_ext = LEN_W'(count_q);
	assign idx_dn    = CNT_W'(idx_q - CNT_W'(1));
	assign idx_up    = CNT_W'(idx_q + CNT_W'(1));

	always_comb begin
		is_ins = 1'b0;
		is_rem = 1'b0;
		at_c   = '0;
		case (action_q)
			ACT_INS_FRONT: begin
				is_ins = 1'b1;
			end
			ACT_INS_BACK: begin
				is_ins = 1'b1;
				at_c   = count_ext;
			end
			ACT_INS_POS: begin
				is_ins = 1'b1;
				at_c   = LEN_W'(pos_q);
			end
			ACT_REM_FRONT: begin
				is_rem = 1'b1;
			end
			ACT_REM_BACK: begin
				is_rem = 1'b1;
				at_c   = LEN_W'(count_ext - LEN_W'(1));
			end
			ACT_REM_POS: begin
				is_rem = 1'b1;
				at_c   = LEN_W'(pos_q);
			end
			default: begin
				at_c = '0;
			end
		endcase
	end

	always_comb begin
		status_c = ST_OK;
		if (is_ins) begin
			if (at_c > count_ext) begin
				status_c = ST_BADPOS;
			end else if (count_ext == LEN_W'(DEPTH)) begin
				status_c = ST_FULL;
			end
		end else if (is_rem) begin
			if (count_q == '0) begin
				status_c = ST_EMPTY;
			end else if (at_c >= count_ext) begin
				status_c = ST_BADPOS;
			end
		end
	end

	assign stat.ins_ok    = is_ins && (status_c == ST_OK);
	assign stat.rem_ok    = is_rem && (status_c == ST_OK);
	assign stat.move_done = dir_q ? (idx_q == at_q) : (idx_up == count_q);

	assign ram_re    = cmd.take_rd || (cmd.move_rd && !stat.move_done);
	assign ram_raddr = cmd.take_rd ? at_q[IDX_W-1:0]
		: (dir_q ? idx_dn[IDX_W-1:0] : idx_up[IDX_W-1:0]);
	assign ram_we    = cmd.move_wr || cmd.put;
	assign ram_waddr = idx_q[IDX_W-1:0];
	assign ram_wdata = cmd.put ? val_q : ram_rdata;

	ple_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= req_action;
			pos_q    <= req_position;
			val_q    <= req_value_in;
		end
		if (cmd.check) begin
			status_q <= status_c;
			dir_q    <= is_ins;
			at_q     <= at_c[CNT_W-1:0];
			idx_q    <= is_ins ? count_q : at_c[CNT_W-1:0];
			taken_q  <= '0;
		end
		if (cmd.take_wr) begin
			taken_q <= ram_rdata;
		end
		if (cmd.move_wr) begin
			idx_q <= dir_q ? idx_dn : idx_up;
		end
		if (cmd.publish) begin
			out_status_q <= status_q;
			out_value_q  <= taken_q;
			out_length_q <= count_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.put) begin
			count_q <= CNT_W'(count_q + CNT_W'(1));
		end else if (cmd.move_rd && stat.move_done && !dir_q) begin
			count_q <= CNT_W'(count_q - CNT_W'(1));
		end
	end

	assign rsp_status    = out_status_q;
	assign rsp_value_out = out_value_q;
	assign rsp_length    = out_length_q;

endmodule

@@ rtl/ple_ctrl.sv @@
// ----------------------------------------------------------------------------
// Positional list controller
// Sequences the check, the removal read, the entry moves, the insertion
// write and the result transfer for one item at a time.
// ----------------------------------------------------------------------------
module ple_ctrl
	import ple_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output ple_cmd_t  cmd,
	input  ple_stat_t stat
);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_CHECK   = 8'b0000_0010,
		S_TAKE_RD = 8'b0000_0100,
		S_TAKE_WR = 8'b0000_1000,
		S_MOVE_RD = 8'b0001_0000,
		S_MOVE_WR = 8'b0010_0000,
		S_PUT     = 8'b0100_0000,
		S_RESULT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = req_valid;
				if (req_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (stat.ins_ok) begin
					state_d = S_MOVE_RD;
				end else if (stat.rem_ok) begin
					state_d = S_TAKE_RD;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_TAKE_RD: begin
				cmd.take_rd = 1'b1;
				state_d     = S_TAKE_WR;
			end
			S_TAKE_WR: begin
				cmd.take_wr = 1'b1;
				state_d     = S_MOVE_RD;
			end
			S_MOVE_RD: begin
				cmd.move_rd = 1'b1;
				if (!stat.move_done) begin
					state_d = S_MOVE_WR;
				end else if (stat.ins_ok) begin
					state_d = S_PUT;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_MOVE_WR: begin
				cmd.move_wr = 1'b1;
				state_d     = S_MOVE_RD;
			end
			S_PUT: begin
				cmd.put = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				cmd.publish = out_free;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// Positional list engine
// A bounded ordered list of signed 32-bit values with insertion and removal
// at the front, the back or a given position.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  req      in         action, position, value_in
//  rsp      out        status, value_out, length
//
// A refused or unused item goes from the check to the result. An insertion
// moves entries and writes the new one; a removal reads out its entry, then
// moves entries. A move is a registered store read and a write one place along.
// Reset empties the list at once; the entry store is not cleared.
// A result waits in the output register while the next item is taken in, and
// a finished item waits in S_RESULT until the previous result has transferred.
// ----------------------------------------------------------------------------
module positional_list_engine
	import ple_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	ple_req_if.sink   req,
	ple_rsp_if.source rsp
);

	ple_cmd_t  cmd;
	ple_stat_t stat;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	ple_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_action    (req.action),
		.req_position  (req.position),
		.req_value_in  (req.value_in),
		.cmd           (cmd),
		.stat          (stat),
		.rsp_status    (rsp.status),
		.rsp_value_out (rsp.value_out),
		.rsp_length    (rsp.length)
	);

endmodule

@@ rtl/ple_checker.sv @@
// ----------------------------------------------------------------------------
// Positional list engine checker
// Watches the engine ports; flags requests and results that break its rules.
// ----------------------------------------------------------------------------
module ple_checker
	import ple_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] rsp_status,
	input logic [VAL_W-1:0]    rsp_value_out,
	input logic [LEN_W-1:0]    rsp_length
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("Response withdrawn before its transfer.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("Request taken while an item is still at work.");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_length <= LEN_W'(DEPTH))
		else $error("Length beyond the list capacity.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> rsp_value_out == '0)
		else $error("Refused action returned a value.");

	a_status_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_status != ST_FULL) || (rsp_length == LEN_W'(DEPTH)))
			&& ((rsp_status != ST_EMPTY) || (rsp_length == '0)))
		else $error("Full or empty status disagrees with the length.");

endmodule

bind positional_list_engine ple_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_value_out (rsp.value_out),
	.rsp_length    (rsp.length)
);
